// ===== design/strobed_beacon_rendezvous_mac_defines.svh =====
// Assertion macros shared by the strobed beacon rendezvous MAC.
// Depends on nothing; included by the files that carry assertions.
`ifndef STROBED_BEACON_RENDEZVOUS_MAC_DEFINES_SVH
`define STROBED_BEACON_RENDEZVOUS_MAC_DEFINES_SVH

// same-cycle implication
`define SBRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbrm: assertion failed");

// next-cycle implication
`define SBRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbrm: assertion failed");

`endif

// ===== design/sbrm_pkg.sv =====
// Types and constants of the strobed beacon rendezvous MAC.
// Depends on nothing; used by sbrm_core, the top level and the testbench.
package sbrm_pkg;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_LISTEN = 2'd1,
		PH_STROBE = 2'd2
	} phase_t;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_PKT   = 2'd2;

	localparam logic [1:0] PKT_BEACON = 2'd0;
	localparam logic [1:0] PKT_ACK    = 2'd1;

	localparam logic [1:0] TX_BEACON = 2'd0;
	localparam logic [1:0] TX_ACK    = 2'd1;
	localparam logic [1:0] TX_SELECT = 2'd2;

	localparam logic [2:0] RX_NONE      = 3'd0;
	localparam logic [2:0] RX_OK        = 3'd1;
	localparam logic [2:0] RX_TIMEOUT   = 3'd2;
	localparam logic [2:0] RX_CRC_FAIL  = 3'd3;
	localparam logic [2:0] RX_BAD_ADDR  = 3'd4;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_OWN_ID     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LISTEN     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACK_WAIT   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_STROBE_WIN = 2'd3;

	localparam int CFG_W     = 20;
	localparam int ELAPSED_W = 21;

	localparam logic [15:0]      LISTEN_RST     = 16'd32;
	localparam logic [15:0]      ACK_WAIT_RST   = 16'd16;
	localparam logic [CFG_W-1:0] STROBE_WIN_RST = 20'h10000;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] rendezvous_in;
		logic [1:0]  pkt_type;
		logic        pkt_crc_ok;
		logic [15:0] pkt_src;
		logic [15:0] pkt_dst;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [1:0]  tx_type;
		logic [15:0] tx_dst;
		logic [15:0] tx_rendezvous;
		logic        round_done;
		logic [15:0] meas_rdv;
		logic [2:0]  rx_status;
		logic        busy_res;
	} result_t;

	typedef struct packed {
		logic [15:0]      own_id;
		logic [15:0]      listen_ticks;
		logic [15:0]      ack_wait_ticks;
		logic [CFG_W-1:0] strobe_window_ticks;
	} cfg_t;

endpackage

// ===== design/sbrm_chan_if.sv =====
// Valid/ready channel carrying one word of a given type.
// Depends on nothing; the word type comes in as a parameter.
interface sbrm_chan_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/sbrm_core.sv =====
// Round state of the MAC and the combinational step that updates it.
// Depends on sbrm_pkg.
module sbrm_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  sbrm_pkg::item_t  item,
	input  sbrm_pkg::cfg_t   cfg,
	output sbrm_pkg::result_t res
);
	import sbrm_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [15:0]            timer_q, timer_d;
	logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
	logic [15:0]            adv_q, adv_d;
	logic [15:0]            meas_q, meas_d;

	logic [2:0]             st;
	logic                   good_ack;
	logic                   good_beacon;
	logic                   timer_exp;
	logic [ELAPSED_W-1:0]   elapsed_inc;
	logic [ELAPSED_W-1:0]   tick_elapsed;
	logic [ELAPSED_W-1:0]   win_ext;
	logic                   tick_open;
	logic                   pkt_open;
	logic [15:0]            meas_ack;
	logic                   active;

	// wrong address wins over a bad CRC
	always_comb begin
		if (item.pkt_dst != 16'd0 && item.pkt_dst != cfg.own_id) begin
			st = RX_BAD_ADDR;
		end else if (!item.pkt_crc_ok) begin
			st = RX_CRC_FAIL;
		end else begin
			st = RX_OK;
		end
	end

	assign good_ack     = (st == RX_OK) && (item.pkt_type == PKT_ACK);
	assign good_beacon  = (st == RX_OK) && (item.pkt_type == PKT_BEACON);
	assign timer_exp    = (timer_q <= 16'd1);
	assign elapsed_inc  = (&elapsed_q) ? elapsed_q : elapsed_q + ELAPSED_W'(1);
	assign tick_elapsed = (phase_q == PH_STROBE) ? elapsed_inc : '0;
	assign win_ext      = ELAPSED_W'(cfg.strobe_window_ticks);
	assign tick_open    = (tick_elapsed < win_ext);
	assign pkt_open     = (elapsed_q < win_ext);
	assign meas_ack     = (elapsed_q[ELAPSED_W-1:16] == '0) ? elapsed_q[15:0] : 16'd0;
	assign active       = (phase_q == PH_LISTEN) || (phase_q == PH_STROBE);

	// next state
	always_comb begin
		phase_d   = active ? phase_q : PH_IDLE;
		timer_d   = timer_q;
		elapsed_d = elapsed_q;
		adv_d     = adv_q;
		meas_d    = meas_q;
		unique case (item.command)
			CMD_START: begin
				adv_d     = item.rendezvous_in;
				meas_d    = 16'd0;
				elapsed_d = '0;
				timer_d   = cfg.listen_ticks;
				phase_d   = PH_LISTEN;
			end
			CMD_TICK: begin
				if (active) begin
					elapsed_d = tick_elapsed;
					if (timer_exp) begin
						timer_d = tick_open ? cfg.ack_wait_ticks : 16'd0;
						phase_d = tick_open ? PH_STROBE : PH_IDLE;
					end else begin
						timer_d = timer_q - 16'd1;
					end
				end
			end
			CMD_PKT: begin
				if (phase_q == PH_LISTEN) begin
					phase_d = PH_IDLE;
				end else if (phase_q == PH_STROBE) begin
					if (good_ack) begin
						meas_d  = meas_ack;
						phase_d = PH_IDLE;
					end else if (pkt_open) begin
						timer_d = cfg.ack_wait_ticks;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result word
	always_comb begin
		res = '0;
		unique case (item.command)
			CMD_TICK: begin
				if (active && timer_exp) begin
					res.rx_status = RX_TIMEOUT;
					if (tick_open) begin
						res.tx_valid      = 1'b1;
						res.tx_type       = TX_BEACON;
						res.tx_rendezvous = adv_q;
					end else begin
						res.round_done = 1'b1;
						res.meas_rdv   = meas_q;
					end
				end
			end
			CMD_PKT: begin
				if (phase_q == PH_LISTEN) begin
					res.rx_status  = st;
					res.round_done = 1'b1;
					res.meas_rdv   = meas_q;
					if (good_beacon) begin
						res.tx_valid      = 1'b1;
						res.tx_type       = TX_ACK;
						res.tx_dst        = item.pkt_src;
						res.tx_rendezvous = adv_q;
					end
				end else if (phase_q == PH_STROBE) begin
					res.rx_status = st;
					if (good_ack) begin
						res.tx_valid      = 1'b1;
						res.tx_type       = TX_SELECT;
						res.tx_dst        = item.pkt_src;
						res.tx_rendezvous = adv_q;
						res.round_done    = 1'b1;
						res.meas_rdv      = meas_ack;
					end else if (pkt_open) begin
						res.tx_valid      = 1'b1;
						res.tx_type       = TX_BEACON;
						res.tx_rendezvous = adv_q;
					end else begin
						res.round_done = 1'b1;
						res.meas_rdv   = meas_q;
					end
				end
			end
			default: begin
			end
		endcase
		res.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= 16'd0;
			elapsed_q <= '0;
			adv_q     <= 16'd0;
			meas_q    <= 16'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			elapsed_q <= elapsed_d;
			adv_q     <= adv_d;
			meas_q    <= meas_d;
		end
	end

endmodule

// ===== design/strobed_beacon_rendezvous_mac.sv =====
// Top level of the strobed beacon rendezvous MAC: config registers, input and result registers.
// Depends on sbrm_pkg, sbrm_chan_if, sbrm_core and the assertion macro header.
//
// One word in, one result word out. Commands are start, timer tick and packet received.
// Each word is held in the input register, where sbrm_core works out the result
// and the round state update, then sits in the result register until taken; a new word
// is taken every cycle while the result side keeps up. The result register is the only
// thing that sets the rate. Config writes belong to idle periods.
`include "strobed_beacon_rendezvous_mac_defines.svh"

module strobed_beacon_rendezvous_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [sbrm_pkg::REG_IDX_W-1:0]  wr_idx,
	input  logic [sbrm_pkg::CFG_W-1:0]      wr_data,
	sbrm_chan_if.sink                       items,
	sbrm_chan_if.source                     results
);
	import sbrm_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	assign advance       = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready   = !valid_s1 || advance;
	assign results.valid = out_valid_q;
	assign results.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id              <= 16'd0;
			cfg_q.listen_ticks        <= LISTEN_RST;
			cfg_q.ack_wait_ticks      <= ACK_WAIT_RST;
			cfg_q.strobe_window_ticks <= STROBE_WIN_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_OWN_ID:     cfg_q.own_id              <= wr_data[15:0];
				REG_LISTEN:     cfg_q.listen_ticks        <= wr_data[15:0];
				REG_ACK_WAIT:   cfg_q.ack_wait_ticks      <= wr_data[15:0];
				REG_STROBE_WIN: cfg_q.strobe_window_ticks <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1 <= items.data;
		end
	end

	sbrm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	`SBRM_ASSERT_NEXT(a_advance_fills_out, clk, arst_n, advance, out_valid_q)
	`SBRM_ASSERT_NEXT(a_stalled_word_kept, clk, arst_n, valid_s1 && !advance, valid_s1)
	`SBRM_ASSERT_NOW(a_done_not_busy, clk, arst_n, out_valid_q && res_q.round_done, !res_q.busy_res)
	`SBRM_ASSERT_NOW(a_select_ends_round, clk, arst_n, out_valid_q && res_q.tx_valid && res_q.tx_type == TX_SELECT, res_q.round_done)
	`SBRM_ASSERT_NOW(a_beacon_keeps_busy, clk, arst_n, out_valid_q && res_q.tx_valid && res_q.tx_type == TX_BEACON, res_q.busy_res)

endmodule

// ===== sim/strobed_beacon_rendezvous_mac_tb.sv =====
// Self-checking testbench for strobed_beacon_rendezvous_mac: directed and random rounds
// through the valid/ready channels, results checked against a round tracker class.
// Depends on sbrm_pkg, sbrm_chan_if and the block itself.
module strobed_beacon_rendezvous_mac_tb;
	import sbrm_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] PKT_SELECT = 2'd2;
	localparam int IDLE_PCT = 38;
	localparam int RX_HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_WORDS = 55;

	class round_tracker;
		logic [15:0] own_id, listen_ticks, ack_wait_ticks;
		logic [CFG_W-1:0] strobe_window_ticks;
		phase_t phase;
		logic [15:0] window_timer;
		logic [ELAPSED_W-1:0] strobe_elapsed;
		logic [15:0] adv_rendezvous, meas_rendezvous;
		result_t due_results[$];
		int unsigned errors;

		function new();
			own_id = '0;
			listen_ticks = LISTEN_RST;
			ack_wait_ticks = ACK_WAIT_RST;
			strobe_window_ticks = STROBE_WIN_RST;
			phase = PH_IDLE;
			window_timer = '0;
			strobe_elapsed = '0;
			adv_rendezvous = '0;
			meas_rendezvous = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_OWN_ID: own_id = value[15:0];
				REG_LISTEN: listen_ticks = value[15:0];
				REG_ACK_WAIT: ack_wait_ticks = value[15:0];
				REG_STROBE_WIN: strobe_window_ticks = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void emit(inout result_t r, input logic [1:0] kind, input logic [15:0] dst);
			r.tx_valid = 1'b1;
			r.tx_type = kind;
			r.tx_dst = dst;
			r.tx_rendezvous = adv_rendezvous;
		endfunction

		function void end_round(inout result_t r);
			phase = PH_IDLE;
			r.round_done = 1'b1;
			r.meas_rdv = meas_rendezvous;
		endfunction

		// beacon while the strobe window is open, otherwise the round is over
		function void launch_beacon(inout result_t r);
			if ({1'b0, strobe_window_ticks} > strobe_elapsed) begin
				emit(r, TX_BEACON, 16'h0);
				window_timer = ack_wait_ticks;
				phase = PH_STROBE;
			end else begin
				end_round(r);
			end
		endfunction

		function void note_word(item_t w);
			result_t r;
			logic [2:0] status;
			r = '0;
			if (w.pkt_dst != 16'h0 && w.pkt_dst != own_id)
				status = RX_BAD_ADDR;
			else if (!w.pkt_crc_ok)
				status = RX_CRC_FAIL;
			else
				status = RX_OK;
			case (w.command)
				CMD_START: begin
					adv_rendezvous = w.rendezvous_in;
					meas_rendezvous = '0;
					strobe_elapsed = '0;
					window_timer = listen_ticks;
					phase = PH_LISTEN;
				end
				CMD_TICK: begin
					if (phase == PH_STROBE && strobe_elapsed != '1)
						strobe_elapsed++;
					if (phase != PH_IDLE) begin
						if (window_timer <= 16'd1) begin
							window_timer = '0;
							r.rx_status = RX_TIMEOUT;
							if (phase == PH_LISTEN)
								strobe_elapsed = '0;
							launch_beacon(r);
						end else begin
							window_timer--;
						end
					end
				end
				CMD_PKT: begin
					if (phase == PH_LISTEN) begin
						r.rx_status = status;
						if (status == RX_OK && w.pkt_type == PKT_BEACON)
							emit(r, TX_ACK, w.pkt_src);
						end_round(r);
					end else if (phase == PH_STROBE) begin
						r.rx_status = status;
						if (status == RX_OK && w.pkt_type == PKT_ACK) begin
							meas_rendezvous = (strobe_elapsed[ELAPSED_W-1:16] == '0) ?
								strobe_elapsed[15:0] : 16'h0;
							emit(r, TX_SELECT, w.pkt_src);
							end_round(r);
						end else begin
							launch_beacon(r);
						end
					end
				end
				default: ;
			endcase
			r.busy_res = (phase != PH_IDLE);
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result word with nothing outstanding: 0x%0h", got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("tx_valid", want.tx_valid, got.tx_valid);
			compare_field("tx_type", want.tx_type, got.tx_type);
			compare_field("tx_dst", want.tx_dst, got.tx_dst);
			compare_field("tx_rendezvous", want.tx_rendezvous, got.tx_rendezvous);
			compare_field("round_done", want.round_done, got.round_done);
			compare_field("meas_rdv", want.meas_rdv, got.meas_rdv);
			compare_field("rx_status", want.rx_status, got.rx_status);
			compare_field("busy_res", want.busy_res, got.busy_res);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_idx;
	logic [CFG_W-1:0] wr_data;

	sbrm_chan_if #(.word_t(item_t)) items_ch ();
	sbrm_chan_if #(.word_t(result_t)) results_ch ();

	strobed_beacon_rendezvous_mac dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data),
		.items(items_ch),
		.results(results_ch)
	);

	round_tracker tracker = new();
	bit calm = 1'b0;
	bit hold_rx = 1'b0;
	int hold_left = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic item_t any_word();
		item_t w;
		w.command = $urandom_range(0, 3);
		w.rendezvous_in = $urandom_range(0, 16'hFFFF);
		w.pkt_type = $urandom_range(0, 3);
		w.pkt_crc_ok = $urandom_range(0, 1);
		w.pkt_src = $urandom_range(0, 16'hFFFF);
		w.pkt_dst = $urandom_range(0, 16'hFFFF);
		return w;
	endfunction

	function automatic item_t cmd_word(logic [1:0] cmd);
		item_t w;
		w = any_word();
		w.command = cmd;
		return w;
	endfunction

	function automatic item_t start_word(logic [15:0] rdv);
		item_t w;
		w = cmd_word(CMD_START);
		w.rendezvous_in = rdv;
		return w;
	endfunction

	function automatic item_t pkt_word(logic [1:0] kind, logic crc, logic [15:0] src,
			logic [15:0] dst);
		item_t w;
		w = cmd_word(CMD_PKT);
		w.pkt_type = kind;
		w.pkt_crc_ok = crc;
		w.pkt_src = src;
		w.pkt_dst = dst;
		return w;
	endfunction

	// mostly well-formed packets, biased toward the type that moves the round on
	function automatic item_t shaped_pkt(logic [1:0] hint);
		item_t w;
		w = cmd_word(CMD_PKT);
		if ($urandom_range(0, 99) < 75) begin
			w.pkt_crc_ok = 1'b1;
			w.pkt_dst = $urandom_range(0, 1) ? tracker.own_id : 16'h0;
		end
		if ($urandom_range(0, 99) < 55)
			w.pkt_type = hint;
		return w;
	endfunction

	function automatic item_t next_word();
		item_t w;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		w = any_word();
		case (tracker.phase)
			PH_LISTEN: begin
				if (roll < 70) w.command = CMD_TICK;
				else if (roll < 92) w = shaped_pkt(PKT_BEACON);
				else if (roll < 96) w.command = CMD_START;
				else w.command = CMD_UNUSED;
			end
			PH_STROBE: begin
				if (roll < 62) w.command = CMD_TICK;
				else if (roll < 94) w = shaped_pkt(PKT_ACK);
				else if (roll < 97) w.command = CMD_START;
				else w.command = CMD_UNUSED;
			end
			default: begin
				if (roll < 85) w.command = CMD_START;
			end
		endcase
		return w;
	endfunction

	task automatic send_word(item_t w);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.data <= w;
		do @(posedge clk); while (!items_ch.ready);
		tracker.note_word(w);
	endtask

	task automatic drain();
		items_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_one(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= value;
		@(posedge clk);
		tracker.set_reg(idx, value);
	endtask

	task automatic program_regs(logic [15:0] own, logic [15:0] listen, logic [15:0] ack_wait,
			logic [CFG_W-1:0] window);
		write_one(REG_OWN_ID, {4'h0, own});
		write_one(REG_LISTEN, {4'h0, listen});
		write_one(REG_ACK_WAIT, {4'h0, ack_wait});
		write_one(REG_STROBE_WIN, window);
		wr_en <= 1'b0;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		results_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready)
				tracker.check_word(results_ch.data);
			if (hold_rx) begin
				hold_left = RX_HOLD_CYCLES;
				hold_rx = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int unsigned stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned counted;
		item_t w;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_data = '0;
		items_ch.valid = 1'b0;
		items_ch.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle events, each packet outcome while listening, restart
		send_word(cmd_word(CMD_TICK));
		send_word(cmd_word(CMD_PKT));
		send_word(cmd_word(CMD_UNUSED));
		send_word(start_word(16'hFFFF));
		send_word(pkt_word(PKT_BEACON, 1'b1, 16'hFFFF, 16'h0));
		send_word(start_word(16'h0));
		send_word(pkt_word(PKT_BEACON, 1'b0, 16'h0, 16'h0005));
		send_word(start_word(16'hA5A5));
		send_word(pkt_word(PKT_BEACON, 1'b0, 16'h1234, 16'h0));
		send_word(start_word(16'h5A5A));
		send_word(pkt_word(PKT_SELECT, 1'b1, 16'h0001, 16'h0));
		send_word(start_word(16'h0F0F));
		send_word(start_word(16'hF0F0));
		send_word(cmd_word(CMD_UNUSED));
		drain();

		// zero timer lengths, a bad ACK while strobing, window running out
		program_regs(16'hFFFF, 16'h0, 16'h0, 20'd2);
		send_word(start_word(16'h8001));
		send_word(cmd_word(CMD_TICK));
		send_word(pkt_word(PKT_ACK, 1'b0, 16'h7FFE, 16'hFFFF));
		send_word(cmd_word(CMD_TICK));
		send_word(cmd_word(CMD_TICK));
		send_word(start_word(16'h1357));
		send_word(cmd_word(CMD_TICK));
		send_word(cmd_word(CMD_TICK));
		send_word(pkt_word(PKT_ACK, 1'b1, 16'h8001, 16'hFFFF));
		drain();

		program_regs(16'h0, 16'd1, 16'd1, 20'd0);
		send_word(start_word(16'h2468));
		send_word(cmd_word(CMD_TICK));
		drain();

		// long strobes with no idling, acked at two neighboring counts
		calm = 1'b1;
		program_regs(16'h0, 16'd1, 16'hFFFF, 20'hFFFFF);
		for (int n = 40; n <= 41; n++) begin
			send_word(start_word(16'hC3C3));
			send_word(cmd_word(CMD_TICK));
			repeat (n) send_word(cmd_word(CMD_TICK));
			send_word(pkt_word(PKT_ACK, 1'b1, 16'h4242, 16'h0));
		end
		drain();
		calm = 1'b0;

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			program_regs(
				(ph % 3 == 0) ? 16'h0 : (ph % 3 == 1) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFE)),
				(ph == 4) ? 16'hFFFF : (ph == 1) ? 16'h0 : 16'($urandom_range(1, 6)),
				(ph == 3) ? 16'hFFFF : (ph == 1) ? 16'h0 : 16'($urandom_range(1, 5)),
				(ph == 5) ? 20'hFFFFF : (ph == 0) ? 20'h0 : 20'($urandom_range(1, 30)));
			if (ph == 2)
				hold_rx = 1'b1;
			counted = 0;
			while (counted < PHASE_WORDS) begin
				w = next_word();
				if (w.command == CMD_START ||
						(tracker.phase != PH_IDLE && w.command != CMD_UNUSED))
					counted++;
				send_word(w);
			end
		end
		drain();
		repeat (8) @(posedge clk);

		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
